@@ rtl/gf64rma_pkg.sv @@
// ============================================================================
// gf64rma_pkg
// Shared types, constants and GF(2^64) helper functions for the region
// multiply-accumulate block.
// ============================================================================
package gf64rma_pkg;

    // Field element width and the low part of x^64 + x^4 + x^3 + x + 1.
    localparam int unsigned DATA_W      = 64;
    localparam int unsigned POLY_LOW_W  = 8;
    localparam logic [POLY_LOW_W-1:0] GF_POLY_LOW = 8'h1B;

    // Width of the overflow left by the first fold (degree of x^4 term).
    localparam int unsigned OVER_W      = 4;

    // The coefficient sum is split into slices for the partial products.
    localparam int unsigned PART_W      = 16;
    localparam int unsigned NUM_PARTS   = DATA_W / PART_W;
    localparam int unsigned PART_PROD_W = DATA_W + PART_W - 1;
    localparam int unsigned PROD_W      = 2 * DATA_W;

    // Configuration port.
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned COUNT_W     = 3;
    localparam int unsigned MAX_COEFFS_DEFAULT = 6;

    typedef logic [DATA_W-1:0]      gf_word_t;
    typedef logic [PART_PROD_W-1:0] part_prod_t;
    typedef logic [PROD_W-1:0]      gf_prod_t;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ACCUMULATE_MODE = 4'd0,
        REG_COEFF_COUNT     = 4'd1,
        REG_COEFF_BASE      = 4'd2
    } cfg_reg_t;

    // Carry-less product of a full word with one coefficient slice.
    function automatic part_prod_t clmul_part(input gf_word_t a,
                                              input logic [PART_W-1:0] b);
        part_prod_t r;
        r = '0;
        for (int i = 0; i < PART_W; i++)
        begin
            if (b[i])
            begin
                r = r ^ (PART_PROD_W'(a) << i);
            end
        end
        return r;
    endfunction

    // Multiply by the low part of the modulus, keeping the low word.
    function automatic gf_word_t times_poly_low(input gf_word_t v);
        gf_word_t r;
        r = '0;
        for (int i = 0; i < POLY_LOW_W; i++)
        begin
            if (GF_POLY_LOW[i])
            begin
                r = r ^ (v << i);
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/gf64_region_mul_accumulate.sv @@
// ============================================================================
// gf64_region_mul_accumulate
// Streams GF(2^64) words, multiplies each by the XOR of the active
// coefficients, reduces modulo x^64+x^4+x^3+x+1 and optionally accumulates.
// ============================================================================
// Throughput: one item per cycle while the output is not stalled; four register stages (capture, partial
// products, product combine, reduction) each advance when the next is free.
// Reset: rst_n clears all stage valid bits and loads the configuration reset
// values (overwrite mode, one coefficient equal to 1).
// The configuration port is always ready; a write is registered and takes effect in the next cycle.
module gf64_region_mul_accumulate #(
    parameter int unsigned MAX_COEFFS = gf64rma_pkg::MAX_COEFFS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: data_value [63:0], prev_value [127:64]
    input  logic [2*gf64rma_pkg::DATA_W-1:0]    s_axis_tdata,
    // tlast: end_of_region
    input  logic                                s_axis_tlast,
    // Output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: result_value [63:0]
    output logic [gf64rma_pkg::DATA_W-1:0]      m_axis_tdata,
    // tlast: end_of_region_out
    output logic                                m_axis_tlast,
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gf64rma_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gf64rma_pkg::DATA_W-1:0]      cfg_data
);
    import gf64rma_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                 accumulate_mode_reg;
    logic [COUNT_W-1:0]   coeff_count_reg;
    gf_word_t             coeff_reg [MAX_COEFFS];
    logic                 cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    // Writes to unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accumulate_mode_reg <= 1'b0;
            coeff_count_reg     <= COUNT_W'(1);
            for (int k = 0; k < MAX_COEFFS; k++)
            begin
                coeff_reg[k] <= (k == 0) ? gf_word_t'(1) : '0;
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_ACCUMULATE_MODE)
            begin
                accumulate_mode_reg <= cfg_data[0];
            end
            if (cfg_index == REG_COEFF_COUNT)
            begin
                coeff_count_reg <= cfg_data[COUNT_W-1:0];
            end
            for (int k = 0; k < MAX_COEFFS; k++)
            begin
                if (cfg_index == CFG_INDEX_W'(REG_COEFF_BASE + k))
                begin
                    coeff_reg[k] <= cfg_data;
                end
            end
        end
    end

    // The sum of products equals one multiply by the XOR of the coefficients.
    logic [COUNT_W-1:0] eff_count;
    gf_word_t           csum;

    always_comb
    begin
        eff_count = (coeff_count_reg > COUNT_W'(MAX_COEFFS)) ?
                    COUNT_W'(MAX_COEFFS) : coeff_count_reg;
        csum = '0;
        for (int k = 0; k < MAX_COEFFS; k++)
        begin
            if (COUNT_W'(k) < eff_count)
            begin
                csum = csum ^ coeff_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or its
    // successor loads in the same cycle.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ld1, ld2, ld3, ld4;

    assign ld4 = !v4_reg || m_axis_tready;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;

    assign s_axis_tready = ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
            if (ld4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage payloads
    // ------------------------------------------------------------------
    gf_word_t   data1_reg, csum1_reg, prev1_reg;
    logic       last1_reg;
    part_prod_t part2_reg [NUM_PARTS];
    gf_word_t   prev2_reg;
    logic       last2_reg;
    gf_word_t   lo3_reg, hi3_reg, prev3_reg;
    logic       last3_reg;
    gf_word_t   result4_reg;
    logic       last4_reg;

    // Product combine and reduction logic.
    gf_prod_t          prod_next;
    gf_word_t          result_next;
    logic [OVER_W-1:0] over;

    always_comb
    begin
        prod_next = '0;
        for (int j = 0; j < NUM_PARTS; j++)
        begin
            prod_next = prod_next ^ (PROD_W'(part2_reg[j]) << (PART_W * j));
        end
    end

    always_comb
    begin
        over = OVER_W'((hi3_reg >> 60) ^ (hi3_reg >> 61) ^ (hi3_reg >> 63));
        result_next = lo3_reg ^ times_poly_low(hi3_reg)
                    ^ times_poly_low(gf_word_t'(over)) ^ prev3_reg;
    end

    always_ff @(posedge clk)
    begin
        // Stage 1: capture the item with the coefficient sum; the previous
        // word is zeroed in overwrite mode.
        if (ld1)
        begin
            data1_reg <= s_axis_tdata[DATA_W-1:0];
            prev1_reg <= s_axis_tdata[2*DATA_W-1:DATA_W] & {DATA_W{accumulate_mode_reg}};
            csum1_reg <= csum;
            last1_reg <= s_axis_tlast;
        end
        // Stage 2: one carry-less partial product per coefficient slice.
        if (ld2)
        begin
            for (int j = 0; j < NUM_PARTS; j++)
            begin
                part2_reg[j] <= clmul_part(data1_reg, csum1_reg[PART_W*j +: PART_W]);
            end
            prev2_reg <= prev1_reg;
            last2_reg <= last1_reg;
        end
        // Stage 3: shift and XOR the partial products into the full product.
        if (ld3)
        begin
            lo3_reg   <= prod_next[DATA_W-1:0];
            hi3_reg   <= prod_next[PROD_W-1:DATA_W];
            prev3_reg <= prev2_reg;
            last3_reg <= last2_reg;
        end
        // Stage 4: two folds of the high word, then accumulate.
        if (ld4)
        begin
            result4_reg <= result_next;
            last4_reg   <= last3_reg;
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = result4_reg;
    assign m_axis_tlast  = last4_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A full pipeline facing a stalled output takes no new item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && v4_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while the pipeline is full and stalled");

    // An item moving out of stage 1 shows up in stage 2.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && ld2) |=> v2_reg)
        else $error("item lost between stage 1 and stage 2");

    // With no active coefficient the captured sum is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && coeff_count_reg == '0) |=> csum1_reg == '0)
        else $error("coefficient sum not zero for a count of zero");

    // In overwrite mode the previous word does not enter the result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !accumulate_mode_reg) |=> prev1_reg == '0)
        else $error("previous word kept in overwrite mode");

endmodule
